### rtl/hsd_pkg.sv
// Package for the Huffman stream decoder: beat types, kind and status codes,
// header constants. No dependencies.
`default_nettype none
package hsd_pkg;

    localparam int MAX_CODE_LEN_DEF = 12;
    localparam int MAX_ENTRIES      = 256;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_symbol;
        logic [2:0] out_status;
        logic       out_last;
    } out_item_t;

    localparam logic KIND_SYM  = 1'b0;
    localparam logic KIND_STAT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_MISMATCH  = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;
    localparam logic [2:0] ST_NO_MATCH  = 3'd5;

    function automatic logic [7:0] magic_byte(input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = 8'h48;
            2'd1:    v = 8'h45;
            2'd2:    v = 8'h33;
            default: v = 8'h0D;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/hsd_entry_ram.sv
// Entry store: (symbol, length) per code table entry, one write and one
// registered read port. Standalone.
`default_nettype none
module hsd_entry_ram #(
    parameter int DW = 12
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [7:0]    wa,
    input  wire logic [DW-1:0] wd,
    input  wire logic [7:0]    ra,
    output logic      [DW-1:0] rd
);
    logic [DW-1:0] mem [256];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end
endmodule
`default_nettype wire

### rtl/hsd_table_ram.sv
// Decode table: one write port, two registered read ports with enable.
// Standalone.
`default_nettype none
module hsd_table_ram #(
    parameter int AW = 13
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] wa,
    input  wire logic [8:0]    wd,
    input  wire logic          re,
    input  wire logic [AW-1:0] ra_a,
    input  wire logic [AW-1:0] ra_b,
    output logic      [8:0]    rd_a,
    output logic      [8:0]    rd_b
);
    logic [8:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_a <= mem[ra_a];
            rd_b <= mem[ra_b];
        end
    end
endmodule
`default_nettype wire

### rtl/hsd_core.sv
// Decoder sequencer: header parse, table build, bit-serial payload decode.
// Uses hsd_pkg, hsd_entry_ram, hsd_table_ram.
`default_nettype none
module hsd_core #(
    parameter int MAX_CODE_LEN = hsd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire hsd_pkg::in_item_t  s_data,
    input  wire logic               out_free,
    output logic                    push_valid,
    output hsd_pkg::out_item_t      push_item
);
    localparam int L   = MAX_CODE_LEN;
    localparam int TAW = L + 1;
    localparam int LW  = $clog2(L + 1);
    localparam int EW  = 8 + LW;

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_CHECK   = 3'd1;
    localparam logic [2:0] PH_COUNT   = 3'd2;
    localparam logic [2:0] PH_NENT    = 3'd3;
    localparam logic [2:0] PH_PAIRS   = 3'd4;
    localparam logic [2:0] PH_CODES   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_DRAIN   = 3'd7;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HDR   = 4'd2;
    localparam logic [3:0] S_CBIT  = 4'd3;
    localparam logic [3:0] S_PLOAD = 4'd4;
    localparam logic [3:0] S_PBIT  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    function automatic logic [TAW-1:0] tidx(input logic [L-1:0] acc, input logic [LW-1:0] n);
        return (TAW'(1) << n) | TAW'(acc);
    endfunction

    logic [3:0]     step_reg, step_next;
    logic [2:0]     phase_reg, phase_next;
    logic [1:0]     hc_reg, hc_next;
    logic [7:0]     exp_chk_reg, exp_chk_next;
    logic [31:0]    sym_total_reg, sym_total_next;
    logic [8:0]     ent_total_reg, ent_total_next;
    logic [8:0]     ent_idx_reg, ent_idx_next;
    logic [7:0]     pair_sym_reg, pair_sym_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic [2:0]     bit_reg, bit_next;
    logic [L-1:0]   acc_reg, acc_next;
    logic [LW-1:0]  nb_reg, nb_next;
    logic [31:0]    done_reg, done_next;
    logic [7:0]     chk_reg, chk_next;
    logic           sel_reg, sel_next;
    logic           pend_v_reg, pend_v_next;
    hsd_pkg::out_item_t pend_reg, pend_next;
    logic [TAW-1:0] clr_reg, clr_next;

    logic           em;
    logic           em_kind;
    logic [7:0]     em_sym;
    logic [2:0]     em_st;
    logic           emit_ok;

    logic           ent_we;
    logic [EW-1:0]  ent_wd;
    logic [EW-1:0]  ent_rd;
    logic           tbl_we, tbl_re;
    logic [TAW-1:0] tbl_wa, tbl_ra_a, tbl_ra_b;
    logic [8:0]     tbl_wd, tbl_rd_a, tbl_rd_b;

    logic [L-1:0]   acc_a;
    logic [LW-1:0]  nb_a;
    logic           cur_bit, nxt_bit;
    logic [8:0]     hit_ent;
    logic [15:0]    full_cnt;
    logic [LW-1:0]  cur_len;
    logic [2:0]     fin_st;

    hsd_entry_ram #(.DW(EW)) u_entry (
        .aclk (aclk),
        .we   (ent_we),
        .wa   (ent_idx_reg[7:0]),
        .wd   (ent_wd),
        .ra   (ent_idx_next[7:0]),
        .rd   (ent_rd)
    );

    hsd_table_ram #(.AW(TAW)) u_table (
        .aclk (aclk),
        .we   (tbl_we),
        .wa   (tbl_wa),
        .wd   (tbl_wd),
        .re   (tbl_re),
        .ra_a (tbl_ra_a),
        .ra_b (tbl_ra_b),
        .rd_a (tbl_rd_a),
        .rd_b (tbl_rd_b)
    );

    assign emit_ok  = !pend_v_reg || out_free;
    assign cur_bit  = byte_reg[bit_reg];
    assign nxt_bit  = byte_reg[3'(bit_reg + 3'd1)];
    assign acc_a    = {acc_reg[L-2:0], cur_bit};
    assign nb_a     = nb_reg + LW'(1);
    assign hit_ent  = sel_reg ? tbl_rd_b : tbl_rd_a;
    assign full_cnt = {byte_reg, ent_total_reg[7:0]};
    assign cur_len  = ent_rd[EW-1:8];
    assign fin_st   = (chk_reg == exp_chk_reg) ? hsd_pkg::ST_OK : hsd_pkg::ST_MISMATCH;

    always_comb begin
        step_next      = step_reg;
        phase_next     = phase_reg;
        hc_next        = hc_reg;
        exp_chk_next   = exp_chk_reg;
        sym_total_next = sym_total_reg;
        ent_total_next = ent_total_reg;
        ent_idx_next   = ent_idx_reg;
        pair_sym_next  = pair_sym_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        bit_next       = bit_reg;
        acc_next       = acc_reg;
        nb_next        = nb_reg;
        done_next      = done_reg;
        chk_next       = chk_reg;
        sel_next       = sel_reg;
        pend_v_next    = pend_v_reg;
        pend_next      = pend_reg;
        clr_next       = clr_reg;
        em             = 1'b0;
        em_kind        = hsd_pkg::KIND_STAT;
        em_sym         = 8'd0;
        em_st          = hsd_pkg::ST_OK;
        push_valid     = 1'b0;
        push_item      = pend_reg;
        s_ready        = 1'b0;
        ent_we         = 1'b0;
        ent_wd         = {byte_reg[LW-1:0], pair_sym_reg};
        tbl_we         = 1'b0;
        tbl_wa         = clr_reg;
        tbl_wd         = 9'd0;
        tbl_re         = 1'b0;
        tbl_ra_a       = tidx(acc_a, nb_a);
        tbl_ra_b       = tidx(L'(nxt_bit), LW'(1));

        unique case (step_reg)
            S_CLEAR: begin
                tbl_we   = 1'b1;
                clr_next = clr_reg + TAW'(1);
                if (&clr_reg) begin
                    step_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    byte_next = s_data.in_byte;
                    last_next = s_data.in_last;
                    bit_next  = 3'd0;
                    if (phase_reg == PH_CODES) begin
                        step_next = S_CBIT;
                    end else if (phase_reg == PH_PAYLOAD) begin
                        step_next = S_PLOAD;
                    end else begin
                        step_next = S_HDR;
                    end
                end
            end
            S_HDR: begin
                step_next = S_END;
                case (phase_reg)
                    PH_MAGIC: begin
                        if (byte_reg != hsd_pkg::magic_byte(hc_reg)) begin
                            em = 1'b1; em_st = hsd_pkg::ST_BAD_MAGIC; phase_next = PH_DRAIN;
                        end else begin
                            hc_next = hc_reg + 2'd1;
                            if (hc_reg == 2'd3) begin
                                phase_next = PH_CHECK;
                            end
                        end
                    end
                    PH_CHECK: begin
                        exp_chk_next = byte_reg;
                        phase_next   = PH_COUNT;
                        hc_next      = 2'd0;
                    end
                    PH_COUNT: begin
                        case (hc_reg)
                            2'd0:    sym_total_next[7:0]   = byte_reg;
                            2'd1:    sym_total_next[15:8]  = byte_reg;
                            2'd2:    sym_total_next[23:16] = byte_reg;
                            default: sym_total_next[31:24] = byte_reg;
                        endcase
                        hc_next = hc_reg + 2'd1;
                        if (hc_reg == 2'd3) begin
                            phase_next = PH_NENT;
                        end
                    end
                    PH_NENT: begin
                        if (hc_reg == 2'd0) begin
                            ent_total_next = {1'b0, byte_reg};
                            hc_next        = 2'd1;
                        end else begin
                            hc_next = 2'd0;
                            if (full_cnt > 16'(hsd_pkg::MAX_ENTRIES)) begin
                                em = 1'b1; em_st = hsd_pkg::ST_BAD_LEN; phase_next = PH_DRAIN;
                            end else begin
                                ent_total_next = full_cnt[8:0];
                                ent_idx_next   = 9'd0;
                                if (full_cnt == 16'd0) begin
                                    phase_next = PH_PAYLOAD;
                                    acc_next   = '0;
                                    nb_next    = '0;
                                    if (sym_total_reg == 32'd0) begin
                                        em = 1'b1; em_st = fin_st; phase_next = PH_DRAIN;
                                    end
                                end else begin
                                    phase_next = PH_PAIRS;
                                end
                            end
                        end
                    end
                    PH_PAIRS: begin
                        if (hc_reg == 2'd0) begin
                            pair_sym_next = byte_reg;
                            hc_next       = 2'd1;
                        end else begin
                            hc_next = 2'd0;
                            if (byte_reg == 8'd0 || byte_reg > 8'(L)) begin
                                em = 1'b1; em_st = hsd_pkg::ST_BAD_LEN; phase_next = PH_DRAIN;
                            end else begin
                                ent_we       = 1'b1;
                                ent_idx_next = ent_idx_reg + 9'd1;
                                if (ent_idx_reg + 9'd1 >= ent_total_reg) begin
                                    phase_next   = PH_CODES;
                                    ent_idx_next = 9'd0;
                                    acc_next     = '0;
                                    nb_next      = '0;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CBIT: begin
                acc_next = acc_a;
                nb_next  = nb_a;
                if (nb_a >= cur_len) begin
                    tbl_we       = 1'b1;
                    tbl_wa       = tidx(acc_a, cur_len);
                    tbl_wd       = {1'b1, ent_rd[7:0]};
                    ent_idx_next = ent_idx_reg + 9'd1;
                    acc_next     = '0;
                    nb_next      = '0;
                end
                if (nb_a >= cur_len && ent_idx_reg + 9'd1 >= ent_total_reg) begin
                    phase_next = PH_PAYLOAD;
                    step_next  = S_END;
                    if (sym_total_reg == 32'd0) begin
                        em = 1'b1; em_st = fin_st; phase_next = PH_DRAIN;
                    end
                end else if (bit_reg == 3'd7) begin
                    step_next = S_END;
                end else begin
                    bit_next = bit_reg + 3'd1;
                end
            end
            S_PLOAD: begin
                tbl_re    = 1'b1;
                acc_next  = acc_a;
                nb_next   = nb_a;
                sel_next  = 1'b0;
                step_next = S_PBIT;
            end
            S_PBIT: begin
                if ((hit_ent[8] || nb_reg >= LW'(L)) && !emit_ok) begin
                    step_next = S_PBIT;
                end else if (hit_ent[8]) begin
                    em        = 1'b1;
                    em_kind   = hsd_pkg::KIND_SYM;
                    em_sym    = hit_ent[7:0];
                    chk_next  = chk_reg ^ hit_ent[7:0];
                    done_next = done_reg + 32'd1;
                    if (done_reg + 32'd1 == sym_total_reg) begin
                        acc_next  = '0;
                        nb_next   = '0;
                        step_next = S_FIN;
                    end else if (bit_reg == 3'd7) begin
                        acc_next  = '0;
                        nb_next   = '0;
                        step_next = S_END;
                    end else begin
                        tbl_re   = 1'b1;
                        tbl_ra_a = tidx(L'(nxt_bit), LW'(1));
                        acc_next = L'(nxt_bit);
                        nb_next  = LW'(1);
                        sel_next = 1'b0;
                        bit_next = bit_reg + 3'd1;
                    end
                end else if (nb_reg >= LW'(L)) begin
                    em = 1'b1; em_st = hsd_pkg::ST_NO_MATCH; phase_next = PH_DRAIN;
                    step_next = S_END;
                end else if (bit_reg == 3'd7) begin
                    step_next = S_END;
                end else begin
                    tbl_re   = 1'b1;
                    tbl_ra_a = tidx({acc_reg[L-2:0], nxt_bit}, nb_a);
                    acc_next = {acc_reg[L-2:0], nxt_bit};
                    nb_next  = nb_a;
                    sel_next = 1'b0;
                    bit_next = bit_reg + 3'd1;
                end
            end
            S_FIN: begin
                if (emit_ok) begin
                    em = 1'b1; em_st = fin_st; phase_next = PH_DRAIN;
                    step_next = S_END;
                end
            end
            S_END: begin
                if (last_reg && phase_reg != PH_DRAIN) begin
                    if (emit_ok) begin
                        em = 1'b1; em_st = hsd_pkg::ST_TRUNC; phase_next = PH_DRAIN;
                        step_next = S_FLUSH;
                    end
                end else begin
                    step_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!pend_v_reg || out_free) begin
                    if (pend_v_reg) begin
                        push_valid         = 1'b1;
                        push_item.out_last = 1'b1;
                        pend_v_next        = 1'b0;
                    end
                    if (last_reg) begin
                        step_next      = S_CLEAR;
                        clr_next       = '0;
                        phase_next     = PH_MAGIC;
                        hc_next        = 2'd0;
                        exp_chk_next   = 8'd0;
                        sym_total_next = 32'd0;
                        ent_total_next = 9'd0;
                        ent_idx_next   = 9'd0;
                        acc_next       = '0;
                        nb_next        = '0;
                        done_next      = 32'd0;
                        chk_next       = 8'd0;
                    end else begin
                        step_next = S_IDLE;
                    end
                end
            end
            default: begin
                step_next = S_CLEAR;
            end
        endcase

        if (em) begin
            if (pend_v_reg) begin
                push_valid         = 1'b1;
                push_item.out_last = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_next   = '{out_kind: em_kind, out_symbol: em_sym,
                            out_status: em_st, out_last: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= S_CLEAR;
            phase_reg     <= PH_MAGIC;
            hc_reg        <= 2'd0;
            exp_chk_reg   <= 8'd0;
            sym_total_reg <= 32'd0;
            ent_total_reg <= 9'd0;
            ent_idx_reg   <= 9'd0;
            last_reg      <= 1'b0;
            bit_reg       <= 3'd0;
            acc_reg       <= '0;
            nb_reg        <= '0;
            done_reg      <= 32'd0;
            chk_reg       <= 8'd0;
            sel_reg       <= 1'b0;
            pend_v_reg    <= 1'b0;
            clr_reg       <= '0;
        end else begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            hc_reg        <= hc_next;
            exp_chk_reg   <= exp_chk_next;
            sym_total_reg <= sym_total_next;
            ent_total_reg <= ent_total_next;
            ent_idx_reg   <= ent_idx_next;
            last_reg      <= last_next;
            bit_reg       <= bit_next;
            acc_reg       <= acc_next;
            nb_reg        <= nb_next;
            done_reg      <= done_next;
            chk_reg       <= chk_next;
            sel_reg       <= sel_next;
            pend_v_reg    <= pend_v_next;
            clr_reg       <= clr_next;
        end
        pair_sym_reg <= pair_sym_next;
        byte_reg     <= byte_next;
        pend_reg     <= pend_next;
    end
endmodule
`default_nettype wire

### rtl/huffman_stream_decoder.sv
// Huffman stream decoder top: core plus output register.
// Uses hsd_pkg and hsd_core.
//
//  channel | ports                      | beat
//  input   | s_valid s_ready s_data     | hsd_pkg::in_item_t, one stream byte
//  output  | m_valid m_ready m_data     | hsd_pkg::out_item_t, symbol or status
//
// Code bytes are consumed bit-serially; payload bytes are decoded one bit
// at a time with one decode-table read per bit. Output backpressure stalls
// the core. After reset and after every in_last beat the decode table is
// cleared, all 2**(MAX_CODE_LEN+1) entries (8192 by default), with s_ready low.
`default_nettype none
module huffman_stream_decoder #(
    parameter int MAX_CODE_LEN = hsd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire hsd_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output hsd_pkg::out_item_t      m_data
);
    logic               m_valid_reg;
    hsd_pkg::out_item_t m_data_reg;
    logic               out_free;
    logic               push_valid;
    hsd_pkg::out_item_t push_item;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    hsd_core #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .out_free   (out_free),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= push_valid;
        end
        if (out_free && push_valid) begin
            m_data_reg <= push_item;
        end
    end

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> out_free)
        else $error("push into a full output register");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !push_valid)
        else $error("result pushed while accepting input");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.in_last) |=> !s_ready)
        else $error("input accepted right after end of stream");
endmodule
`default_nettype wire
